// File: hdl/bqt_pkg.sv
// shared constants, widths and helpers for the biquadratic patch tessellator
package bqt_pkg;

	localparam int COORD_W   = 32;
	localparam int NUM_ATTR  = 7;
	localparam int NUM_SLOTS = 9;
	localparam int NUM_WORDS = NUM_SLOTS * NUM_ATTR;
	localparam int LEVEL_W   = 6;
	localparam int SLOT_W    = 4;
	localparam int WEIGHT_W  = 17;
	localparam int SQ_W      = 2 * LEVEL_W;
	localparam int PROD_W    = COORD_W + WEIGHT_W + 1;
	localparam int ACC_W     = COORD_W + 4;

	localparam int S_TDATA_W = 240;
	localparam int M_TDATA_W = 240;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_ROW  = 1'b1;

	localparam logic REG_TESS_LEVEL = 1'b0;
	localparam logic [LEVEL_W-1:0] TESS_LEVEL_RESET = LEVEL_W'(8);

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [WEIGHT_W-1:0] weight_t;

	function automatic coord_t sat_coord(input logic signed [ACC_W-1:0] x);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = ACC_W'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
		lo = -hi - ACC_W'(1);
		if (x > hi) begin
			return coord_t'(hi);
		end else if (x < lo) begin
			return coord_t'(lo);
		end else begin
			return coord_t'(x);
		end
	endfunction

endpackage

// File: hdl/biquadratic_patch_tessellator.sv
// biquadratic bezier patch tessellator, top level
//
// channel   dir  handshake         contents
// s_*       in   tvalid / tready   tuser command, tdata slot, row and seven attributes
// m_*       out  tvalid / tready   tdata row, column and seven blended values, tlast row end
// apb       in   psel / penable    tess_level at byte address 0
//
// a load writes its seven attribute words to the store, one word per cycle
// a row computes each weight with the one-bit-a-cycle divider and each blend term
// with one pass through the shared multiplier
// s_tready is high only while idle; the next vertex is computed while one waits on m_*
// arst_n clears the sequencer, the output valid and tess_level (reset 8)
module biquadratic_patch_tessellator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// point_index, row_index, in_pos_x, in_pos_y, in_pos_z, in_tex_s, in_tex_t,
	// in_light_s, in_light_t, zero fill
	input  logic [bqt_pkg::S_TDATA_W-1:0]  s_tdata,
	// command
	input  logic [0:0]                     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// grid_row, grid_column, out_pos_x, out_pos_y, out_pos_z, out_tex_s, out_tex_t,
	// out_light_s, out_light_t, zero fill
	output logic [bqt_pkg::M_TDATA_W-1:0]  m_tdata,
	// row_last
	output logic                           m_tlast,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bqt_pkg::PADDR_W-1:0]    paddr,
	input  logic [bqt_pkg::PDATA_W-1:0]    pwdata,
	output logic [bqt_pkg::PDATA_W-1:0]    prdata,
	output logic                           pready
);
	import bqt_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DISP = 4'd1;
	localparam logic [3:0] ST_LOAD = 4'd2;
	localparam logic [3:0] ST_WSET = 4'd3;
	localparam logic [3:0] ST_WDIV = 4'd4;
	localparam logic [3:0] ST_RRD  = 4'd5;
	localparam logic [3:0] ST_RMUL = 4'd6;
	localparam logic [3:0] ST_RACC = 4'd7;
	localparam logic [3:0] ST_CMUL = 4'd8;
	localparam logic [3:0] ST_CACC = 4'd9;
	localparam logic [3:0] ST_EMIT = 4'd10;

	localparam int WORD_AW = 6;
	localparam int ROWV_N  = 3 * NUM_ATTR;
	localparam int ROWV_AW = 5;

	logic [3:0]           state_q;
	logic [LEVEL_W-1:0]   tess_level_q;
	logic                 cmd_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [LEVEL_W-1:0]   row_q;
	coord_t               attr_q [NUM_ATTR];
	logic [2:0]           attr_cnt_q;
	logic [1:0]           term_q;
	logic [1:0]           grp_q;
	logic [LEVEL_W-1:0]   col_q;
	logic [1:0]           widx_q;
	logic                 phase_q;
	logic [4:0]           div_cnt_q;
	logic [SQ_W-1:0]      rem_q;
	logic [WEIGHT_W-1:0]  num_q;
	logic [WEIGHT_W-1:0]  quo_q;
	weight_t              w_q [3];
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [PROD_W-1:0] prod_q;
	coord_t               rd_q;
	coord_t               rowv_q [ROWV_N];
	coord_t               res_q [NUM_ATTR];
	coord_t               mem [NUM_WORDS];
	logic                 out_valid_q;
	logic [LEVEL_W-1:0]   out_row_q;
	logic [LEVEL_W-1:0]   out_col_q;
	coord_t               out_attr_q [NUM_ATTR];
	logic                 out_last_q;

	logic                 s_acc;
	logic                 cfg_wr;
	logic [LEVEL_W-1:0]   k_val;
	logic [LEVEL_W-1:0]   r_val;
	logic [SQ_W-1:0]      lvl_sq;
	logic [SQ_W-1:0]      m_val;
	logic [SQ_W:0]        trial;
	logic                 qbit;
	logic [SLOT_W-1:0]    rd_slot;
	logic [WORD_AW-1:0]   mem_addr;
	logic                 mem_we;
	logic [ROWV_AW-1:0]   rowv_idx;
	coord_t               mul_a;
	logic signed [ACC_W-1:0] acc_next;
	logic                 emit_go;
	logic                 last_col;

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == REG_TESS_LEVEL);
	assign prdata   = (paddr[2] == REG_TESS_LEVEL) ? PDATA_W'(tess_level_q) : '0;

	// weight numerators and the denominator
	assign k_val  = phase_q ? col_q : row_q;
	assign r_val  = tess_level_q - k_val;
	assign lvl_sq = SQ_W'(tess_level_q) * SQ_W'(tess_level_q);
	always_comb begin
		unique case (widx_q)
			2'd0:    m_val = SQ_W'(r_val) * SQ_W'(r_val);
			2'd1:    m_val = SQ_W'({SQ_W'(k_val) * SQ_W'(r_val), 1'b0});
			default: m_val = SQ_W'(k_val) * SQ_W'(k_val);
		endcase
	end

	assign trial = {rem_q, num_q[WEIGHT_W-1]};
	assign qbit  = (trial >= {1'b0, lvl_sq});

	// store addressing
	assign rd_slot  = SLOT_W'(grp_q) * SLOT_W'(3) + SLOT_W'(term_q);
	assign mem_we   = (state_q == ST_LOAD);
	assign mem_addr = mem_we ? WORD_AW'(slot_q) * WORD_AW'(NUM_ATTR) + WORD_AW'(attr_cnt_q)
	                         : WORD_AW'(rd_slot) * WORD_AW'(NUM_ATTR) + WORD_AW'(attr_cnt_q);

	assign rowv_idx = (state_q == ST_RACC)
	                ? ROWV_AW'(grp_q) * ROWV_AW'(NUM_ATTR) + ROWV_AW'(attr_cnt_q)
	                : ROWV_AW'(term_q) * ROWV_AW'(NUM_ATTR) + ROWV_AW'(attr_cnt_q);

	// shared multiplier operand
	assign mul_a = (state_q == ST_RMUL) ? rd_q : rowv_q[rowv_idx];

	assign acc_next = ((term_q == 2'd0) ? ACC_W'(0) : acc_q)
	                + ACC_W'($signed(prod_q[PROD_W-1:16]));

	assign emit_go  = (state_q == ST_EMIT) && (!out_valid_q || m_tready);
	assign last_col = (col_q == tess_level_q);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= attr_q[attr_cnt_q];
		end
		rd_q <= mem[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tess_level_q <= TESS_LEVEL_RESET;
		end else if (cfg_wr) begin
			tess_level_q <= pwdata[LEVEL_W-1:0];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			attr_cnt_q <= '0;
			term_q     <= '0;
			grp_q      <= '0;
			col_q      <= '0;
			widx_q     <= '0;
			phase_q    <= 1'b0;
			div_cnt_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						state_q <= ST_DISP;
					end
				end
				ST_DISP: begin
					attr_cnt_q <= '0;
					term_q     <= '0;
					grp_q      <= '0;
					col_q      <= '0;
					widx_q     <= '0;
					phase_q    <= 1'b0;
					if (cmd_q == CMD_LOAD) begin
						state_q <= (slot_q < SLOT_W'(NUM_SLOTS)) ? ST_LOAD : ST_IDLE;
					end else if (tess_level_q == '0 || row_q > tess_level_q) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_WSET;
					end
				end
				ST_LOAD: begin
					if (attr_cnt_q == 3'(NUM_ATTR - 1)) begin
						attr_cnt_q <= '0;
						state_q    <= ST_IDLE;
					end else begin
						attr_cnt_q <= attr_cnt_q + 3'd1;
					end
				end
				ST_WSET: begin
					div_cnt_q <= '0;
					state_q   <= ST_WDIV;
				end
				ST_WDIV: begin
					div_cnt_q <= div_cnt_q + 5'd1;
					if (div_cnt_q == 5'(WEIGHT_W - 1)) begin
						if (widx_q == 2'd2) begin
							widx_q     <= '0;
							attr_cnt_q <= '0;
							term_q     <= '0;
							state_q    <= phase_q ? ST_CMUL : ST_RRD;
						end else begin
							widx_q  <= widx_q + 2'd1;
							state_q <= ST_WSET;
						end
					end
				end
				ST_RRD: begin
					state_q <= ST_RMUL;
				end
				ST_RMUL: begin
					state_q <= ST_RACC;
				end
				ST_RACC: begin
					if (term_q == 2'd2) begin
						term_q <= '0;
						if (attr_cnt_q == 3'(NUM_ATTR - 1)) begin
							attr_cnt_q <= '0;
							if (grp_q == 2'd2) begin
								grp_q   <= '0;
								col_q   <= '0;
								phase_q <= 1'b1;
								state_q <= ST_WSET;
							end else begin
								grp_q   <= grp_q + 2'd1;
								state_q <= ST_RRD;
							end
						end else begin
							attr_cnt_q <= attr_cnt_q + 3'd1;
							state_q    <= ST_RRD;
						end
					end else begin
						term_q  <= term_q + 2'd1;
						state_q <= ST_RRD;
					end
				end
				ST_CMUL: begin
					state_q <= ST_CACC;
				end
				ST_CACC: begin
					if (term_q == 2'd2) begin
						term_q <= '0;
						if (attr_cnt_q == 3'(NUM_ATTR - 1)) begin
							attr_cnt_q <= '0;
							state_q    <= ST_EMIT;
						end else begin
							attr_cnt_q <= attr_cnt_q + 3'd1;
							state_q    <= ST_CMUL;
						end
					end else begin
						term_q  <= term_q + 2'd1;
						state_q <= ST_CMUL;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						if (last_col) begin
							state_q <= ST_IDLE;
						end else begin
							col_q   <= col_q + LEVEL_W'(1);
							state_q <= ST_WSET;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (s_acc) begin
			cmd_q  <= s_tuser[0];
			slot_q <= s_tdata[3:0];
			row_q  <= s_tdata[9:4];
			for (int a = 0; a < NUM_ATTR; a++) begin
				attr_q[a] <= s_tdata[10 + a*COORD_W +: COORD_W];
			end
		end
		if (state_q == ST_WSET) begin
			rem_q <= {1'b0, m_val[SQ_W-1:1]};
			num_q <= {m_val[0], (WEIGHT_W-1)'(0)};
			quo_q <= '0;
		end
		if (state_q == ST_WDIV) begin
			rem_q <= qbit ? SQ_W'(trial - {1'b0, lvl_sq}) : SQ_W'(trial);
			num_q <= {num_q[WEIGHT_W-2:0], 1'b0};
			quo_q <= {quo_q[WEIGHT_W-2:0], qbit};
			if (div_cnt_q == 5'(WEIGHT_W - 1)) begin
				w_q[widx_q] <= {quo_q[WEIGHT_W-2:0], qbit};
			end
		end
		if (state_q == ST_RMUL || state_q == ST_CMUL) begin
			prod_q <= mul_a * $signed({1'b0, w_q[term_q]});
		end
		if (state_q == ST_RACC || state_q == ST_CACC) begin
			acc_q <= acc_next;
			if (term_q == 2'd2) begin
				if (state_q == ST_RACC) begin
					rowv_q[rowv_idx] <= sat_coord(acc_next);
				end else begin
					res_q[attr_cnt_q] <= sat_coord(acc_next);
				end
			end
		end
		if (emit_go) begin
			out_row_q  <= row_q;
			out_col_q  <= col_q;
			out_last_q <= last_col;
			for (int a = 0; a < NUM_ATTR; a++) begin
				out_attr_q[a] <= res_q[a];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {4'b0, out_attr_q[6], out_attr_q[5], out_attr_q[4], out_attr_q[3],
	                   out_attr_q[2], out_attr_q[1], out_attr_q[0], out_col_q, out_row_q};

endmodule

// File: hdl/bqt_checker.sv
// port-level checks for the biquadratic patch tessellator
module bqt_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [bqt_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                          m_tlast
);
	import bqt_pkg::*;

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");

	// mid-row the block is still busy
	a_busy_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input ready before row finished");

	// column zero never ends a row
	a_col0_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[11:6] == 6'd0) |-> !m_tlast)
		else $error("row ended on column zero");

	// the row number never exceeds the level, which is the last column
	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> (m_tdata[5:0] <= m_tdata[11:6]))
		else $error("row beyond level");

	// ready drops again after every accepted input word
	a_multi_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready right after accept");

endmodule

bind biquadratic_patch_tessellator bqt_checker u_bqt_checker (.*);
